[design/gwwtl_pkg.sv]
// shared types and constants of the word-wrap tile layout block
package gwwtl_pkg;

	// grid size
	localparam int COLS = 30;
	localparam int ROWS = 5;

	// derived widths
	localparam int ADDR_W = (COLS > 1) ? $clog2(COLS) : 1;
	localparam int COL_W = $clog2(COLS + 1);
	localparam int ROW_W = $clog2(ROWS + 1);
	localparam int CODE_W = 8;
	localparam int ORG_W = 12;
	localparam int PIX_W = 13;
	localparam int TILE_SHIFT = 3;
	localparam int CFG_IDX_W = 1;

	localparam logic [CODE_W-1:0] SPACE_CODE = 8'h20;
	localparam logic [CODE_W-1:0] LINE_FEED_CODE = 8'h0A;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_X = 1'b0,
		REG_ORIGIN_Y = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [CODE_W-1:0] char_code;
		logic              end_of_message;
	} in_item_t;

	typedef struct packed {
		logic [PIX_W-1:0]  pixel_x;
		logic [PIX_W-1:0]  pixel_y;
		logic [CODE_W-1:0] tile_code;
		logic              tile_valid;
		logic              run_last;
		logic              message_done;
	} out_item_t;

	// sequencer to tile output stage
	typedef struct packed {
		logic             rd;
		logic             flush;
		logic             done;
		logic [PIX_W-1:0] px;
		logic [PIX_W-1:0] py;
	} emit_req_t;

	typedef struct packed {
		logic issue_ok;
		logic flush_ok;
	} emit_sts_t;

endpackage

[design/gwwtl_wbuf.sv]
// word buffer: one write port, one read port with registered read data
module gwwtl_wbuf (
	input  logic                              clk,
	input  logic                              we,
	input  logic [gwwtl_pkg::ADDR_W-1:0]      waddr,
	input  logic [gwwtl_pkg::CODE_W-1:0]      wdata,
	input  logic                              re,
	input  logic [gwwtl_pkg::ADDR_W-1:0]      raddr,
	output logic [gwwtl_pkg::CODE_W-1:0]      rdata
);

	logic [gwwtl_pkg::CODE_W-1:0] mem_q [gwwtl_pkg::COLS];
	logic [gwwtl_pkg::CODE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[design/gwwtl_ctrl.sv]
// layout sequencer: cursor state, word placement and buffer access
module gwwtl_ctrl (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  gwwtl_pkg::in_item_t                  in_data,
	input  logic                                 cfg_wr_en,
	input  logic [gwwtl_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gwwtl_pkg::ORG_W-1:0]          cfg_wdata,
	output gwwtl_pkg::emit_req_t                 req,
	input  gwwtl_pkg::emit_sts_t                 sts,
	output logic                                 mem_we,
	output logic [gwwtl_pkg::ADDR_W-1:0]         mem_waddr,
	output logic [gwwtl_pkg::CODE_W-1:0]         mem_wdata,
	output logic [gwwtl_pkg::ADDR_W-1:0]         mem_raddr
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_PLACE = 5'b00010,
		ST_EMIT  = 5'b00100,
		ST_AFTER = 5'b01000,
		ST_FLUSH = 5'b10000
	} state_t;

	state_t state_q, state_d;

	logic [gwwtl_pkg::CODE_W-1:0] code_q, code_d;
	logic                         last_q, last_d;
	logic                         second_q, second_d;
	logic [gwwtl_pkg::COL_W-1:0]  wl_q, wl_d;
	logic [gwwtl_pkg::COL_W-1:0]  col_q, col_d;
	logic [gwwtl_pkg::ROW_W-1:0]  row_q, row_d;
	logic                         exh_q, exh_d;
	logic [gwwtl_pkg::COL_W-1:0]  cnt_q, cnt_d;
	logic [gwwtl_pkg::ADDR_W-1:0] idx_q, idx_d;
	logic [gwwtl_pkg::ORG_W-1:0]  origin_x_q;
	logic [gwwtl_pkg::ORG_W-1:0]  origin_y_q;

	logic                         in_space, in_lf, q_space, q_lf;
	logic                         wl_full, col_lt, row_over;
	logic [gwwtl_pkg::ROW_W:0]    row_inc;
	logic [gwwtl_pkg::COL_W:0]    fit_sum;
	state_t                       end_state;

	assign in_space = (in_data.char_code == gwwtl_pkg::SPACE_CODE);
	assign in_lf    = (in_data.char_code == gwwtl_pkg::LINE_FEED_CODE);
	assign q_space  = (code_q == gwwtl_pkg::SPACE_CODE);
	assign q_lf     = (code_q == gwwtl_pkg::LINE_FEED_CODE);
	assign wl_full  = (wl_q == gwwtl_pkg::COL_W'(gwwtl_pkg::COLS));
	assign col_lt   = (col_q < gwwtl_pkg::COL_W'(gwwtl_pkg::COLS));
	assign row_inc  = {1'b0, row_q} + 1'b1;
	assign row_over = (row_inc >= (gwwtl_pkg::ROW_W + 1)'(gwwtl_pkg::ROWS));
	assign fit_sum  = {1'b0, col_q} + {1'b0, wl_q};
	// after the main action, an end-of-message item still places what is buffered
	assign end_state = last_q ? ST_PLACE : ST_FLUSH;

	assign in_ready  = (state_q == ST_IDLE);
	assign mem_raddr = idx_q;

	always_comb begin
		state_d   = state_q;
		code_d    = code_q;
		last_d    = last_q;
		second_d  = second_q;
		wl_d      = wl_q;
		col_d     = col_q;
		row_d     = row_q;
		exh_d     = exh_q;
		cnt_d     = cnt_q;
		idx_d     = idx_q;
		req       = '0;
		mem_we    = 1'b0;
		mem_waddr = wl_q[gwwtl_pkg::ADDR_W-1:0];
		mem_wdata = code_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					code_d   = in_data.char_code;
					last_d   = in_data.end_of_message;
					second_d = 1'b0;
					if (exh_q) begin
						if (in_data.end_of_message) begin
							second_d = 1'b1;
							state_d  = ST_PLACE;
						end
					end else if (in_space || in_lf || wl_full) begin
						state_d = ST_PLACE;
					end else begin
						// letter that fits: buffer it right away
						mem_we    = 1'b1;
						mem_wdata = in_data.char_code;
						wl_d      = wl_q + 1'b1;
						if (in_data.end_of_message) begin
							second_d = 1'b1;
							state_d  = ST_PLACE;
						end
					end
				end
			end
			ST_PLACE: begin
				wl_d  = '0;
				cnt_d = wl_q;
				idx_d = '0;
				if (wl_q == '0 || exh_q) begin
					state_d = ST_AFTER;
				end else if (col_q != '0 &&
						fit_sum > (gwwtl_pkg::COL_W + 1)'(gwwtl_pkg::COLS)) begin
					row_d = row_inc[gwwtl_pkg::ROW_W-1:0];
					if (row_over) begin
						// out of rows: the word is dropped
						exh_d   = 1'b1;
						state_d = ST_AFTER;
					end else begin
						col_d   = '0;
						state_d = ST_EMIT;
					end
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.issue_ok) begin
					req.rd = 1'b1;
					req.px = gwwtl_pkg::PIX_W'(origin_x_q) +
						(gwwtl_pkg::PIX_W'(col_q) << gwwtl_pkg::TILE_SHIFT);
					req.py = gwwtl_pkg::PIX_W'(origin_y_q) +
						(gwwtl_pkg::PIX_W'(row_q) << gwwtl_pkg::TILE_SHIFT);
					col_d  = col_q + 1'b1;
					idx_d  = idx_q + 1'b1;
					cnt_d  = cnt_q - 1'b1;
					if (cnt_q == gwwtl_pkg::COL_W'(1)) begin
						state_d = ST_AFTER;
					end
				end
			end
			ST_AFTER: begin
				if (second_q) begin
					state_d = ST_FLUSH;
				end else begin
					if (q_space) begin
						if (!exh_q && col_lt) begin
							col_d = col_q + 1'b1;
						end
					end else if (q_lf) begin
						if (!exh_q) begin
							row_d = row_inc[gwwtl_pkg::ROW_W-1:0];
							if (row_over) begin
								exh_d = 1'b1;
							end else begin
								col_d = '0;
							end
						end
					end else if (!exh_q) begin
						// letter that overflowed a full buffer starts the next piece;
						// all reads of the old piece were issued before this write
						mem_we = 1'b1;
						wl_d   = wl_q + 1'b1;
					end
					second_d = last_q;
					state_d  = end_state;
				end
			end
			ST_FLUSH: begin
				req.flush = 1'b1;
				req.done  = last_q;
				if (sts.flush_ok) begin
					state_d  = ST_IDLE;
					second_d = 1'b0;
					if (last_q) begin
						wl_d  = '0;
						col_d = '0;
						row_d = '0;
						exh_d = 1'b0;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			last_q     <= 1'b0;
			second_q   <= 1'b0;
			wl_q       <= '0;
			col_q      <= '0;
			row_q      <= '0;
			exh_q      <= 1'b0;
			cnt_q      <= '0;
			idx_q      <= '0;
			origin_x_q <= '0;
			origin_y_q <= '0;
		end else begin
			state_q  <= state_d;
			last_q   <= last_d;
			second_q <= second_d;
			wl_q     <= wl_d;
			col_q    <= col_d;
			row_q    <= row_d;
			exh_q    <= exh_d;
			cnt_q    <= cnt_d;
			idx_q    <= idx_d;
			if (cfg_wr_en) begin
				if (cfg_index == gwwtl_pkg::REG_ORIGIN_X) begin
					origin_x_q <= cfg_wdata;
				end else begin
					origin_y_q <= cfg_wdata;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		code_q <= code_d;
	end

endmodule

[design/gwwtl_emit.sv]
// tile output stage: read-data stage, held last tile and output register
module gwwtl_emit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  gwwtl_pkg::emit_req_t          req,
	output gwwtl_pkg::emit_sts_t          sts,
	input  logic [gwwtl_pkg::CODE_W-1:0]  rdata,
	output logic                          out_valid,
	input  logic                          out_ready,
	output gwwtl_pkg::out_item_t          out_data
);

	logic                        vld_s1;
	logic [gwwtl_pkg::PIX_W-1:0] px_s1;
	logic [gwwtl_pkg::PIX_W-1:0] py_s1;
	gwwtl_pkg::out_item_t        pend_q;
	logic                        pend_vld_q;
	gwwtl_pkg::out_item_t        out_q;
	logic                        out_vld_q;

	logic o_free, s1_adv, fire_flush;

	assign o_free     = !out_vld_q || out_ready;
	// the newest tile waits in pend_q until the next one or the end of the item
	assign s1_adv     = vld_s1 && (!pend_vld_q || o_free);
	assign fire_flush = req.flush && sts.flush_ok;

	assign sts.issue_ok = !vld_s1 || s1_adv;
	assign sts.flush_ok = !vld_s1 && (o_free || (!pend_vld_q && !req.done));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (req.rd) begin
				vld_s1 <= 1'b1;
			end else if (s1_adv) begin
				vld_s1 <= 1'b0;
			end
			if (s1_adv) begin
				pend_vld_q <= 1'b1;
			end else if (fire_flush) begin
				pend_vld_q <= 1'b0;
			end
			if ((s1_adv && pend_vld_q) || (fire_flush && (pend_vld_q || req.done))) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd) begin
			px_s1 <= req.px;
			py_s1 <= req.py;
		end
		if (s1_adv) begin
			pend_q <= '{
				pixel_x:      px_s1,
				pixel_y:      py_s1,
				tile_code:    rdata,
				tile_valid:   1'b1,
				run_last:     1'b0,
				message_done: 1'b0
			};
		end
		if (s1_adv && pend_vld_q) begin
			out_q <= pend_q;
		end else if (fire_flush && pend_vld_q) begin
			out_q <= '{
				pixel_x:      pend_q.pixel_x,
				pixel_y:      pend_q.pixel_y,
				tile_code:    pend_q.tile_code,
				tile_valid:   pend_q.tile_valid,
				run_last:     1'b1,
				message_done: req.done
			};
		end else if (fire_flush && req.done) begin
			// end of message with nothing placed
			out_q <= '{
				pixel_x:      '0,
				pixel_y:      '0,
				tile_code:    '0,
				tile_valid:   1'b0,
				run_last:     1'b1,
				message_done: 1'b1
			};
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

endmodule

[design/greedy_word_wrap_tile_layout.sv]
// Greedy word-wrap tile layout: message bytes in, one 8-pixel tile per letter out.
// A letter inside a word is taken while idle and only written to the word buffer; a
// byte that arrives after the rows ran out is taken while idle and dropped. An item
// that ends a word (space, line feed, a letter hitting a full buffer, or an
// end-of-message letter) goes through a setup step, then one tile per cycle through
// the single read port of the word buffer while the output stage accepts them, then
// a step to update the cursor and one to close the item's results. An end-of-message
// space or line feed adds a second, empty placement pass, and an end-of-message
// letter that hits a full buffer adds a second pass for its single tile.
// Each item's last result is held back one tile so it can carry run_last and
// message_done. The user must write origin_x and origin_y through the cfg port only
// while idle; the block itself does not enforce it.
module greedy_word_wrap_tile_layout (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  gwwtl_pkg::in_item_t               in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output gwwtl_pkg::out_item_t              out_data,
	input  logic                              cfg_wr_en,
	input  logic [gwwtl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gwwtl_pkg::ORG_W-1:0]       cfg_wdata
);

	gwwtl_pkg::emit_req_t          req;
	gwwtl_pkg::emit_sts_t          sts;
	logic                          mem_we;
	logic [gwwtl_pkg::ADDR_W-1:0]  mem_waddr;
	logic [gwwtl_pkg::CODE_W-1:0]  mem_wdata;
	logic [gwwtl_pkg::ADDR_W-1:0]  mem_raddr;
	logic [gwwtl_pkg::CODE_W-1:0]  mem_rdata;

	gwwtl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.sts       (sts),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr)
	);

	gwwtl_wbuf u_wbuf (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (req.rd),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	gwwtl_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.sts       (sts),
		.rdata     (mem_rdata),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

[design/gwwtl_checker.sv]
// port-level checks of the tile layout block and their bind
module gwwtl_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input gwwtl_pkg::out_item_t              out_data
);

	localparam logic [gwwtl_pkg::PIX_W-1:0] MAX_X =
		gwwtl_pkg::PIX_W'((2 ** gwwtl_pkg::ORG_W - 1) + 8 * (gwwtl_pkg::COLS - 1));
	localparam logic [gwwtl_pkg::PIX_W-1:0] MAX_Y =
		gwwtl_pkg::PIX_W'((2 ** gwwtl_pkg::ORG_W - 1) + 8 * (gwwtl_pkg::ROWS - 1));

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	// an empty result only closes a message, with all fields zero
	a_empty_tile: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.tile_valid |->
			out_data.message_done && out_data.run_last && out_data.pixel_x == '0 &&
			out_data.pixel_y == '0 && out_data.tile_code == '0)
		else $error("malformed empty result");

	// the final result of a message also closes its item
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.message_done |-> out_data.run_last)
		else $error("message_done without run_last");

	// tiles stay inside the grid
	a_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.tile_valid |->
			out_data.pixel_x <= MAX_X && out_data.pixel_y <= MAX_Y)
		else $error("tile outside the grid");

	// no new byte is taken while a result that does not close its item waits on a stalled output
	a_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready && !out_data.run_last |-> !(in_valid && in_ready))
		else $error("byte accepted in the middle of a result run");

endmodule

bind greedy_word_wrap_tile_layout gwwtl_checker u_gwwtl_checker (.*);

[sim/tb_greedy_word_wrap_tile_layout.sv]
// testbench for the word-wrap tile layout block: random messages, tile prediction, scoreboard
import gwwtl_pkg::*;

typedef logic [CODE_W-1:0] byte_q_t[$];

class tile_scoreboard;
	logic [ORG_W-1:0]  org_x;
	logic [ORG_W-1:0]  org_y;
	logic [CODE_W-1:0] word_buf [COLS];
	int                word_len;
	int                col;
	int                row;
	bit                exhausted;
	out_item_t         tiles_due[$];
	out_item_t         step_tiles[$];
	int                errors;
	int                beats;
	int                messages;
	int                tiles_seen;
	int                blanks_seen;

	function new();
		org_x = '0;
		org_y = '0;
		word_len = 0;
		col = 0;
		row = 0;
		exhausted = 1'b0;
		errors = 0;
		beats = 0;
		messages = 0;
		tiles_seen = 0;
		blanks_seen = 0;
	endfunction

	function void set_origin(cfg_reg_t idx, logic [ORG_W-1:0] value);
		if (idx == REG_ORIGIN_X) begin
			org_x = value;
		end else begin
			org_y = value;
		end
	endfunction

	function bit next_row();
		row++;
		if (row >= ROWS) begin
			exhausted = 1'b1;
			return 1'b0;
		end
		col = 0;
		return 1'b1;
	endfunction

	function void place_word();
		int len;
		out_item_t t;
		len = word_len;
		word_len = 0;
		if (len == 0 || exhausted)
			return;
		// a word that does not fit wraps, unless it already starts the row
		if (col != 0 && col + len > COLS) begin
			if (!next_row())
				return;
		end
		if (col + len > COLS)
			len = COLS - col;
		for (int i = 0; i < len; i++) begin
			t = '0;
			t.pixel_x = PIX_W'(org_x) + PIX_W'(col << TILE_SHIFT);
			t.pixel_y = PIX_W'(org_y) + PIX_W'(row << TILE_SHIFT);
			t.tile_code = word_buf[i];
			t.tile_valid = 1'b1;
			step_tiles.push_back(t);
			col++;
		end
	endfunction

	function void note_input(in_item_t beat);
		out_item_t t;
		step_tiles.delete();
		beats++;
		if (!exhausted) begin
			if (beat.char_code == SPACE_CODE) begin
				place_word();
				if (!exhausted && col < COLS)
					col++;
			end else if (beat.char_code == LINE_FEED_CODE) begin
				place_word();
				if (!exhausted)
					void'(next_row());
			end else begin
				// full buffer: flush the held piece before taking the new letter
				if (word_len >= COLS)
					place_word();
				if (!exhausted && word_len < COLS) begin
					word_buf[word_len] = beat.char_code;
					word_len++;
				end
			end
		end
		if (beat.end_of_message) begin
			place_word();
			if (step_tiles.size() == 0) begin
				t = '0;
				step_tiles.push_back(t);
			end
			t = step_tiles.pop_back();
			t.message_done = 1'b1;
			step_tiles.push_back(t);
			word_len = 0;
			col = 0;
			row = 0;
			exhausted = 1'b0;
			messages++;
		end
		if (step_tiles.size() > 0) begin
			t = step_tiles.pop_back();
			t.run_last = 1'b1;
			step_tiles.push_back(t);
		end
		foreach (step_tiles[i])
			tiles_due.push_back(step_tiles[i]);
	endfunction

	function void compare_field(string name, logic [PIX_W-1:0] want, logic [PIX_W-1:0] got);
		if (got !== want) begin
			errors++;
			if (errors <= 100)
				$error("%s mismatch: expected %0d, got %0d", name, want, got);
		end
	endfunction

	function void check_result(out_item_t got);
		out_item_t want;
		if (tiles_due.size() == 0) begin
			errors++;
			if (errors <= 100)
				$error("result with no tile due: x %0d y %0d code %0d", got.pixel_x,
					got.pixel_y, got.tile_code);
			return;
		end
		want = tiles_due.pop_front();
		if (want.tile_valid)
			tiles_seen++;
		else
			blanks_seen++;
		compare_field("pixel_x", want.pixel_x, got.pixel_x);
		compare_field("pixel_y", want.pixel_y, got.pixel_y);
		compare_field("tile_code", want.tile_code, got.tile_code);
		compare_field("tile_valid", want.tile_valid, got.tile_valid);
		compare_field("run_last", want.run_last, got.run_last);
		compare_field("message_done", want.message_done, got.message_done);
	endfunction
endclass

module tb_greedy_word_wrap_tile_layout;

	localparam int LIMIT = 1000000;
	localparam int SETTLE = 64;
	localparam int PHASE_BEATS = 12;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	in_item_t             in_data;
	logic                 out_valid;
	logic                 out_ready;
	out_item_t            out_data;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [ORG_W-1:0]     cfg_wdata;

	int cycle_count = 0;
	int beats_sent = 0;
	tile_scoreboard sb = new();

	greedy_word_wrap_tile_layout dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_input(in_data);
			if (out_valid && out_ready)
				sb.check_result(out_data);
		end
	end

	// mostly short gaps, a few long ones, and whole windows with none
	function automatic int pick_gap();
		int r;
		if (((cycle_count / 600) % 5) == 2)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 35)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [CODE_W-1:0] pick_letter();
		logic [CODE_W-1:0] c;
		do begin
			c = CODE_W'($urandom_range(0, 255));
		end while (c == SPACE_CODE || c == LINE_FEED_CODE);
		return c;
	endfunction

	function automatic byte_q_t make_message();
		byte_q_t msg;
		int words;
		int len;
		int r;
		int lf_pct;
		bit noisy;
		msg = {};
		words = $urandom_range(1, 6);
		lf_pct = ($urandom_range(0, 3) == 0) ? 70 : 12;
		noisy = ($urandom_range(0, 4) == 0);
		for (int w = 0; w < words; w++) begin
			len = ($urandom_range(0, 99) < 6) ? $urandom_range(COLS - 2, COLS + 12)
				: $urandom_range(1, 5);
			repeat (len) msg.push_back(pick_letter());
			r = $urandom_range(0, 99);
			if (r < lf_pct) begin
				repeat ($urandom_range(1, 2)) msg.push_back(LINE_FEED_CODE);
			end else if (r < 95) begin
				repeat ($urandom_range(1, 3)) msg.push_back(SPACE_CODE);
			end else begin
				// long run of spaces to push the column into saturation
				repeat ($urandom_range(COLS - 4, COLS + 3)) msg.push_back(SPACE_CODE);
			end
		end
		// half the messages end on a letter so the final beat places a word
		if ($urandom_range(0, 1)) begin
			while (msg.size() > 1 && (msg[msg.size()-1] == SPACE_CODE
					|| msg[msg.size()-1] == LINE_FEED_CODE))
				void'(msg.pop_back());
		end
		if (noisy) begin
			repeat ($urandom_range(1, 4))
				msg.insert($urandom_range(0, msg.size()), CODE_W'($urandom_range(0, 255)));
		end
		return msg;
	endfunction

	task automatic send_beat(logic [CODE_W-1:0] code, logic eom);
		int gap;
		in_item_t beat;
		gap = pick_gap();
		beat.char_code = code;
		beat.end_of_message = eom;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= beat;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		beats_sent++;
	endtask

	task automatic send_message(byte_q_t msg);
		foreach (msg[i])
			send_beat(msg[i], i == msg.size() - 1);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.tiles_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_origins(logic [ORG_W-1:0] x, logic [ORG_W-1:0] y);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_ORIGIN_X;
		cfg_wdata <= x;
		@(posedge clk);
		sb.set_origin(REG_ORIGIN_X, x);
		cfg_index <= REG_ORIGIN_Y;
		cfg_wdata <= y;
		@(posedge clk);
		sb.set_origin(REG_ORIGIN_Y, y);
		cfg_wr_en <= 1'b0;
	endtask

	// receiver side: random stalls on out_ready
	initial begin
		int n;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			n = pick_gap();
			if (n > 0) begin
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	initial begin
		while (cycle_count < LIMIT) @(posedge clk);
		$display("timeout after %0d cycles with %0d tiles outstanding", cycle_count,
			sb.tiles_due.size());
		$display("Verification failed");
		$finish;
	end

	initial begin
		byte_q_t msg;
		int phase_start;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_wr_en <= 1'b0;
		cfg_index <= REG_ORIGIN_X;
		cfg_wdata <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_origins('0, '0);
		// extreme letter codes, word closed by the final letter
		msg = {8'h00, 8'hFF, SPACE_CODE, 8'h41};
		send_message(msg);
		// messages that place nothing end on an empty tile
		msg = {SPACE_CODE};
		send_message(msg);
		msg = {LINE_FEED_CODE};
		send_message(msg);
		// rows used up: the word on the last row is still placed, later letters ignored
		msg = {LINE_FEED_CODE, LINE_FEED_CODE, LINE_FEED_CODE, LINE_FEED_CODE, 8'h42,
			LINE_FEED_CODE, 8'h43, 8'h44};
		send_message(msg);
		msg = {8'h7F, 8'h80, 8'h55, 8'hAA, LINE_FEED_CODE, 8'h01, SPACE_CODE};
		send_message(msg);
		msg = {SPACE_CODE, SPACE_CODE, 8'h5A};
		send_message(msg);

		for (int p = 0; p < 4; p++) begin
			wait_idle();
			case (p)
				0: set_origins('1, '1);
				1: set_origins(ORG_W'($urandom_range(0, 4095)), ORG_W'($urandom_range(0, 4095)));
				2: set_origins('0, '1);
				default: set_origins('1, '0);
			endcase
			phase_start = beats_sent;
			while (beats_sent - phase_start < PHASE_BEATS) begin
				msg = make_message();
				send_message(msg);
			end
		end
		wait_idle();

		$display("%0d beats in %0d messages, %0d tiles and %0d empty ends checked",
			sb.beats, sb.messages, sb.tiles_seen, sb.blanks_seen);
		$display("origins swept over five settings including both extremes");
		if (sb.errors == 0 && sb.tiles_due.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
